// ===== rtl/sebfc_pkg.sv =====
// shared types, constants and helpers of the stx/etx bcc frame checker
`timescale 1ns / 1ps

package sebfc_pkg;

    localparam int BYTE_W          = 8;
    localparam int CMD_BYTES       = 6;
    localparam int CMD_W           = CMD_BYTES * BYTE_W;
    localparam int COUNT_W         = 4;
    localparam int TAIL_LEN        = 5;
    localparam int STATUS_W        = 3;
    localparam int CFG_INDEX_W     = 1;
    localparam int MIN_FRAME_LEN   = 14;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam logic [BYTE_W-1:0] STX_BYTE = 8'h02;
    localparam logic [BYTE_W-1:0] ETX_BYTE = 8'h03;
    localparam logic [BYTE_W-1:0] CR_BYTE  = 8'h0D;
    localparam logic [BYTE_W-1:0] LF_BYTE  = 8'h0A;

    // "0054  "
    localparam logic [CMD_W-1:0] EXPECTED_COMMAND_RST = 48'h3030_3534_2020;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_EXPECTED_COMMAND = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CHECK_ENABLE     = 1'd1;

    // verdict codes
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_SHORT     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FRAMING   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_COMMAND   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_CHECK     = 3'd4;
    localparam logic [STATUS_W-1:0] ST_TERMINATE = 3'd5;

    typedef struct packed {
        logic [BYTE_W-1:0] rx_byte;
        logic              frame_end;
    } t_in_req;

    typedef struct packed {
        logic [STATUS_W-1:0] frame_status;
        logic [BYTE_W-1:0]   computed_check;
    } t_out_req;

    // what the front hands to the back for one finished frame
    typedef struct packed {
        logic              short_frame;
        logic              framing_ok;
        logic              cmd_match;
        logic [BYTE_W-1:0] check;
        logic [BYTE_W-1:0] hex_hi;
        logic [BYTE_W-1:0] hex_lo;
        logic [BYTE_W-1:0] cr;
        logic [BYTE_W-1:0] lf;
    } t_summary;

    // upper-case ascii hex digit of the low nibble
    function automatic logic [BYTE_W-1:0] hex_digit(input logic [3:0] nib);
        logic [BYTE_W-1:0] v;
        v = {4'h0, nib};
        if (nib < 4'd10) begin
            hex_digit = 8'h30 + v;
        end else begin
            hex_digit = 8'h37 + v;
        end
    endfunction

endpackage

// ===== rtl/sebfc_front.sv =====
// front: per-byte frame tracking, hands a summary to the queue at frame end
`timescale 1ns / 1ps

module sebfc_front
    import sebfc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in_req          i_in_req,
    input  logic [CMD_W-1:0] i_expected_command,
    input  logic             i_queue_full,
    output logic             o_push,
    output t_summary         o_summary
);

    logic [COUNT_W-1:0] r_byte_count, n_byte_count;
    logic [BYTE_W-1:0]  r_running_xor, n_running_xor;
    logic               r_start_ok, n_start_ok;
    logic               r_cmd_match, n_cmd_match;
    logic [BYTE_W-1:0]  r_tail [TAIL_LEN];

    logic              w_fire;
    logic [BYTE_W-1:0] w_byte;
    logic [BYTE_W-1:0] w_want;
    logic              w_in_cmd;
    logic [BYTE_W-1:0] w_check;

    assign w_fire     = i_in_valid && !i_queue_full;
    assign o_in_stall = i_queue_full;
    assign w_byte     = i_in_req.rx_byte;

    // expected byte for positions 1..6, first one in the top byte
    always_comb begin
        w_in_cmd = 1'b1;
        w_want   = '0;
        case (r_byte_count)
            4'd1:    w_want = i_expected_command[5*BYTE_W +: BYTE_W];
            4'd2:    w_want = i_expected_command[4*BYTE_W +: BYTE_W];
            4'd3:    w_want = i_expected_command[3*BYTE_W +: BYTE_W];
            4'd4:    w_want = i_expected_command[2*BYTE_W +: BYTE_W];
            4'd5:    w_want = i_expected_command[1*BYTE_W +: BYTE_W];
            4'd6:    w_want = i_expected_command[0 +: BYTE_W];
            default: w_in_cmd = 1'b0;
        endcase
    end

    always_comb begin
        n_start_ok    = (r_byte_count == '0) ? (w_byte == STX_BYTE) : r_start_ok;
        n_cmd_match   = r_cmd_match && !(w_in_cmd && (w_byte != w_want));
        n_running_xor = r_running_xor;
        if (r_byte_count >= COUNT_W'(CMD_BYTES)) begin
            n_running_xor = r_running_xor ^ r_tail[TAIL_LEN-1];
        end
        // the etx byte, one slot short of the window's end, joins the check at frame end
        w_check = n_running_xor;
        if (r_byte_count >= COUNT_W'(TAIL_LEN)) begin
            w_check = n_running_xor ^ r_tail[TAIL_LEN-2];
        end
        n_byte_count = (r_byte_count != COUNT_MAX) ? r_byte_count + 1'b1 : r_byte_count;
    end

    assign o_push = w_fire && i_in_req.frame_end;

    always_comb begin
        o_summary.short_frame = r_byte_count < COUNT_W'(MIN_FRAME_LEN - 1);
        o_summary.framing_ok  = n_start_ok && (r_tail[TAIL_LEN-2] == ETX_BYTE);
        o_summary.cmd_match   = n_cmd_match;
        o_summary.check       = w_check;
        o_summary.hex_hi      = r_tail[2];
        o_summary.hex_lo      = r_tail[1];
        o_summary.cr          = r_tail[0];
        o_summary.lf          = w_byte;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_push) begin
            r_byte_count  <= '0;
            r_running_xor <= '0;
            r_start_ok    <= 1'b0;
            r_cmd_match   <= 1'b1;
            for (int k = 0; k < TAIL_LEN; k++) begin
                r_tail[k] <= '0;
            end
        end else if (w_fire) begin
            r_byte_count  <= n_byte_count;
            r_running_xor <= n_running_xor;
            r_start_ok    <= n_start_ok;
            r_cmd_match   <= n_cmd_match;
            r_tail[0]     <= w_byte;
            for (int k = 1; k < TAIL_LEN; k++) begin
                r_tail[k] <= r_tail[k-1];
            end
        end
    end

    a_frame_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |=> (r_byte_count == '0) && r_cmd_match && !r_start_ok)
        else $error("frame state not cleared after frame end");

    a_count_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && !i_in_req.frame_end && r_byte_count != COUNT_MAX)
            |=> r_byte_count == $past(r_byte_count) + 1'b1)
        else $error("byte count did not advance");

endmodule

// ===== rtl/sebfc_queue.sv =====
// short fifo of frame summaries between front and back
`timescale 1ns / 1ps

module sebfc_queue
    import sebfc_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_summary i_wdata,
    input  logic     i_pop,
    output logic     o_full,
    output logic     o_valid,
    output t_summary o_head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    t_summary           r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]   r_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full || i_pop)
        else $error("summary pushed into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("summary popped from empty queue");

endmodule

// ===== rtl/sebfc_back.sv =====
// back: turns a frame summary into the verdict and holds it for the consumer
`timescale 1ns / 1ps

module sebfc_back
    import sebfc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_check_enable,
    input  logic     i_q_valid,
    input  t_summary i_q_head,
    output logic     o_q_pop,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_out_req o_out_req
);

    logic     r_out_valid;
    t_out_req r_out_req;
    t_out_req n_out_req;

    assign o_q_pop = i_q_valid && (!r_out_valid || !i_out_stall);

    // first failing check decides
    always_comb begin
        n_out_req.computed_check = i_q_head.check;
        if (i_q_head.short_frame) begin
            n_out_req.frame_status = ST_SHORT;
        end else if (!i_q_head.framing_ok) begin
            n_out_req.frame_status = ST_FRAMING;
        end else if (i_check_enable && !i_q_head.cmd_match) begin
            n_out_req.frame_status = ST_COMMAND;
        end else if (i_q_head.hex_hi != hex_digit(i_q_head.check[7:4]) ||
                     i_q_head.hex_lo != hex_digit(i_q_head.check[3:0])) begin
            n_out_req.frame_status = ST_CHECK;
        end else if (i_q_head.cr != CR_BYTE || i_q_head.lf != LF_BYTE) begin
            n_out_req.frame_status = ST_TERMINATE;
        end else begin
            n_out_req.frame_status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_q_pop) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_out_req <= n_out_req;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out_req;

    a_pop_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |=> r_out_valid)
        else $error("popped summary did not reach the output");

endmodule

// ===== rtl/stx_etx_bcc_frame_checker_unit.sv =====
// top level of the stx/etx xor bcc frame checker
// order: a frame's verdict is written into the queue at the edge that takes its frame_end byte,
//   then loads the output reg once that is empty or not stalled, and shows on o_out_valid
// throughput: one byte request per cycle, set by the front's state update;
//   bytes stall only while the queue holds QUEUE_DEPTH verdicts behind a stalled output
// reset: synchronous active-low i_rst_n clears frame state, queue and output valid,
//   and loads the configuration registers with their reset values
`timescale 1ns / 1ps

module stx_etx_bcc_frame_checker_unit
    import sebfc_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // byte requests
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  t_in_req                i_in_req,
    // verdict requests
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output t_out_req               o_out_req,
    // configuration writes
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CMD_W-1:0]       i_cfg_data
);

    // configuration registers
    logic [CMD_W-1:0] r_expected_command;
    logic             r_check_enable;

    // front to queue
    logic     w_push;
    t_summary w_summary;
    logic     w_queue_full;

    // queue to back
    logic     w_q_valid;
    logic     w_q_pop;
    t_summary w_q_head;

    // register writes must land only while the block is idle; the block does not enforce it, so no shadowing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected_command <= EXPECTED_COMMAND_RST;
            r_check_enable     <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_EXPECTED_COMMAND: r_expected_command <= i_cfg_data;
                CFG_CHECK_ENABLE:     r_check_enable     <= i_cfg_data[0];
                default:              r_check_enable     <= r_check_enable;
            endcase
        end
    end

    // front tracks the frame byte by byte and classifies it at its last byte
    sebfc_front u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_in_req           (i_in_req),
        .i_expected_command (r_expected_command),
        .i_queue_full       (w_queue_full),
        .o_push             (w_push),
        .o_summary          (w_summary)
    );

    // decouples byte intake from a stalled verdict consumer
    sebfc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_wdata (w_summary),
        .i_pop   (w_q_pop),
        .o_full  (w_queue_full),
        .o_valid (w_q_valid),
        .o_head  (w_q_head)
    );

    // back resolves the verdict priority and drives the output register
    sebfc_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_check_enable (r_check_enable),
        .i_q_valid      (w_q_valid),
        .i_q_head       (w_q_head),
        .o_q_pop        (w_q_pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_req      (o_out_req)
    );

endmodule

// ===== verif/frame_verdict_checker.sv =====
// scoreboard for the frame checker: predicts each frame verdict and compares it
`timescale 1ns / 1ps

module frame_verdict_checker
    import sebfc_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  logic                   i_in_stall,
    input  t_in_req                i_in_req,
    input  logic                   i_out_valid,
    input  logic                   i_out_stall,
    input  t_out_req               i_out_req,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CMD_W-1:0]       i_cfg_data,
    output int                     o_fail_count,
    output int                     o_pending
);

    logic [CMD_W-1:0]   cmd_ref;
    logic               cmd_check_on;
    logic [COUNT_W-1:0] seen_count;
    logic [BYTE_W-1:0]  bcc_acc;
    logic               stx_seen;
    logic               cmd_ok;
    logic [BYTE_W-1:0]  tail [TAIL_LEN];
    t_out_req           pending_verdicts [$];
    int                 fails = 0;

    function automatic logic [BYTE_W-1:0] ascii_hex(input logic [3:0] nib);
        logic [BYTE_W-1:0] n8;
        n8 = {4'd0, nib};
        return (nib > 4'd9) ? 8'h41 + n8 - 8'd10 : 8'h30 + n8;
    endfunction

    task automatic clear_frame();
        seen_count = '0;
        bcc_acc    = '0;
        stx_seen   = 1'b0;
        cmd_ok     = 1'b1;
        foreach (tail[k]) tail[k] = '0;
    endtask

    // updates the frame state with one byte, queues a verdict on the last byte
    task automatic take_byte(input t_in_req r);
        int unsigned         pos;
        logic [BYTE_W-1:0]   oldest;
        logic [BYTE_W-1:0]   check;
        logic [STATUS_W-1:0] status;
        pos    = seen_count;
        oldest = tail[TAIL_LEN-1];
        if (pos == 0) begin
            stx_seen = (r.rx_byte == STX_BYTE);
        end else if (pos <= CMD_BYTES) begin
            if (r.rx_byte != cmd_ref[BYTE_W*(CMD_BYTES-pos) +: BYTE_W]) cmd_ok = 1'b0;
        end
        // byte leaving the tail joins the check
        if (pos > TAIL_LEN) bcc_acc ^= oldest;
        for (int k = TAIL_LEN - 1; k > 0; k--) tail[k] = tail[k-1];
        tail[0] = r.rx_byte;
        if (seen_count != COUNT_MAX) seen_count++;
        if (!r.frame_end) return;

        check = bcc_acc;
        if (pos >= TAIL_LEN) check ^= tail[TAIL_LEN-1];
        if (pos + 1 < MIN_FRAME_LEN) begin
            status = ST_SHORT;
        end else if (!stx_seen || tail[4] != ETX_BYTE) begin
            status = ST_FRAMING;
        end else if (cmd_check_on && !cmd_ok) begin
            status = ST_COMMAND;
        end else if (tail[3] != ascii_hex(check[7:4]) || tail[2] != ascii_hex(check[3:0])) begin
            status = ST_CHECK;
        end else if (tail[1] != CR_BYTE || tail[0] != LF_BYTE) begin
            status = ST_TERMINATE;
        end else begin
            status = ST_OK;
        end
        pending_verdicts.push_back('{frame_status: status, computed_check: check});
        clear_frame();
    endtask

    always @(posedge i_clk) begin
        t_out_req want;
        if (!i_rst_n) begin
            cmd_ref      = EXPECTED_COMMAND_RST;
            cmd_check_on = 1'b1;
            clear_frame();
            pending_verdicts.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_EXPECTED_COMMAND) begin
                    cmd_ref = i_cfg_data;
                end else if (i_cfg_index == CFG_CHECK_ENABLE) begin
                    cmd_check_on = i_cfg_data[0];
                end
            end
            if (i_out_valid && !i_out_stall) begin
                if (pending_verdicts.size() == 0) begin
                    $error("verdict request with no frame pending: status %0d check %02h",
                           i_out_req.frame_status, i_out_req.computed_check);
                    fails++;
                end else begin
                    want = pending_verdicts.pop_front();
                    if (i_out_req.frame_status !== want.frame_status) begin
                        $error("frame_status expected %0d actual %0d",
                               want.frame_status, i_out_req.frame_status);
                        fails++;
                    end
                    if (i_out_req.computed_check !== want.computed_check) begin
                        $error("computed_check expected %02h actual %02h",
                               want.computed_check, i_out_req.computed_check);
                        fails++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) take_byte(i_in_req);
        end
        o_fail_count <= fails;
        o_pending    <= pending_verdicts.size();
    end

endmodule

// ===== verif/tb.sv =====
// stimulus and verdict for the stx/etx bcc frame checker testbench
`timescale 1ns / 1ps

module tb;
    import sebfc_pkg::*;

    localparam int ITEMS_PER_PHASE = 320;
    localparam int PHASES          = 6;
    localparam int RX_HOLD_CYCLES  = 200;
    // margin waited after the last verdict is back
    localparam int SETTLE_CYCLES   = 4;
    localparam int MAX_GAP         = 20;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   in_valid  = 1'b0;
    t_in_req                in_req    = '0;
    logic                   in_stall;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    t_out_req               out_req;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = CFG_EXPECTED_COMMAND;
    logic [CMD_W-1:0]       cfg_data  = '0;

    int fail_count;
    int pending;

    // idling knobs shared by the sender and receiver processes
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    bit rx_hold_req = 1'b0;
    int hold_count  = 0;
    int bytes_sent  = 0;

    // command the frame builder uses, tracks what was written to the block
    logic [CMD_W-1:0]  cmd_now       = EXPECTED_COMMAND_RST;
    logic              cmd_check_now = 1'b1;
    logic [BYTE_W-1:0] frame_buf [$];

    stx_etx_bcc_frame_checker_unit uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_req    (in_req),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_req   (out_req),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    frame_verdict_checker verdict_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_req     (in_req),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_req    (out_req),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // receiver: random stall, or a long hold-off when requested
    initial begin
        forever begin
            @(posedge clk);
            if (rx_hold_req) begin
                hold_count++;
                if (hold_count >= RX_HOLD_CYCLES) begin
                    rx_hold_req = 1'b0;
                    hold_count  = 0;
                end
            end
            out_stall <= rx_hold_req || ($urandom_range(99) < rx_idle_pct);
        end
    end

    // run limit, well beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic logic [BYTE_W-1:0] hex_char(input logic [3:0] nib);
        return (nib < 4'd10) ? 8'h30 + {4'd0, nib} : 8'h41 + {4'd0, nib} - 8'd10;
    endfunction

    // one byte request, with a random idle gap before it, held until taken
    task automatic offer_byte(input logic [BYTE_W-1:0] b, input logic last);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < tx_idle_pct) gap++;
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_req   <= '{rx_byte: b, frame_end: last};
        @(posedge clk);
        while (in_stall) @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_frame();
        foreach (frame_buf[k]) offer_byte(frame_buf[k], k == frame_buf.size() - 1);
    endtask

    // well-formed frame: stx, command, payload, etx, bcc in hex, cr lf
    task automatic build_good_frame(input int n_data);
        logic [BYTE_W-1:0] bcc;
        frame_buf.delete();
        frame_buf.push_back(STX_BYTE);
        for (int k = 0; k < CMD_BYTES; k++) begin
            // with the command check off, the command bytes are often junk
            if (cmd_check_now || $urandom_range(1) == 0) begin
                frame_buf.push_back(cmd_now[BYTE_W*(CMD_BYTES-1-k) +: BYTE_W]);
            end else begin
                frame_buf.push_back(BYTE_W'($urandom));
            end
        end
        for (int k = 0; k < n_data; k++) frame_buf.push_back(BYTE_W'($urandom));
        frame_buf.push_back(ETX_BYTE);
        bcc = '0;
        for (int k = 1; k < frame_buf.size(); k++) bcc ^= frame_buf[k];
        frame_buf.push_back(hex_char(bcc[7:4]));
        frame_buf.push_back(hex_char(bcc[3:0]));
        frame_buf.push_back(CR_BYTE);
        frame_buf.push_back(LF_BYTE);
    endtask

    // some good frames, the rest broken in one place, cut short, or noise
    task automatic send_random_frame();
        int kind;
        int n;
        int nb;
        int at;
        int len;
        kind = $urandom_range(99);
        // mostly short payloads, a few long ones; four or more payload bytes saturate the count
        n = ($urandom_range(9) == 0) ? $urandom_range(2, 48) : $urandom_range(2, 8);
        build_good_frame(n);
        nb = frame_buf.size();
        if (kind < 40) begin
            // leave it well formed
        end else if (kind < 48) begin
            frame_buf[0] ^= BYTE_W'($urandom_range(1, 255));
        end else if (kind < 56) begin
            frame_buf[nb-5] ^= BYTE_W'($urandom_range(1, 255));
        end else if (kind < 64) begin
            at = $urandom_range(1, CMD_BYTES);
            frame_buf[at] ^= BYTE_W'($urandom_range(1, 255));
        end else if (kind < 72) begin
            at = nb - 4 + $urandom_range(1);
            // lower-case hex letter is a bad check too
            if (frame_buf[at] >= 8'h41 && $urandom_range(1) == 0) begin
                frame_buf[at] |= 8'h20;
            end else begin
                frame_buf[at] ^= BYTE_W'($urandom_range(1, 255));
            end
        end else if (kind < 80) begin
            at = nb - 2 + $urandom_range(1);
            frame_buf[at] ^= BYTE_W'($urandom_range(1, 255));
        end else if (kind < 90) begin
            len = $urandom_range(1, MIN_FRAME_LEN - 1);
            while (frame_buf.size() > len) void'(frame_buf.pop_back());
        end else begin
            len = $urandom_range(1, 40);
            frame_buf.delete();
            for (int k = 0; k < len; k++) frame_buf.push_back(BYTE_W'($urandom));
            if ($urandom_range(1) == 0) frame_buf[0] = STX_BYTE;
        end
        send_frame();
    endtask

    // stop sending and wait until every verdict is back and the block is quiet
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_regs(input logic [CMD_W-1:0] cmd, input logic on);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_EXPECTED_COMMAND;
        cfg_data  <= cmd;
        @(posedge clk);
        cfg_index <= CFG_CHECK_ENABLE;
        cfg_data  <= {{(CMD_W-1){1'b0}}, on};
        @(posedge clk);
        cfg_we        <= 1'b0;
        cmd_now       = cmd;
        cmd_check_now = on;
    endtask

    initial begin
        int               phase_start;
        logic [CMD_W-1:0] cmd_pick;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int p = 0; p < PHASES; p++) begin
            // sender light / receiver heavy, then swapped, then no idling
            tx_idle_pct = (p < 2) ? 13 : (p < 4) ? 70 : 0;
            rx_idle_pct = (p < 2) ? 70 : (p < 4) ? 13 : 0;
            if (p != 0) drain();
            cmd_pick = {16'($urandom), $urandom};
            case (p)
                0: begin
                    // reset command: a minimal good frame, then one-byte frames
                    build_good_frame(2);
                    send_frame();
                    offer_byte(8'hFF, 1'b1);
                    offer_byte(8'h00, 1'b1);
                end
                1: write_regs('0, 1'b1);
                2: write_regs('1, 1'b1);
                3: write_regs(cmd_pick, 1'b0);
                4: begin
                    write_regs(cmd_pick, 1'b1);
                    // long receiver hold-off while one-byte frames pile up
                    rx_hold_req = 1'b1;
                    for (int k = 0; k < 16; k++) offer_byte(BYTE_W'($urandom), 1'b1);
                end
                default: write_regs(EXPECTED_COMMAND_RST, 1'b0);
            endcase
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < ITEMS_PER_PHASE) send_random_frame();
        end

        drain();
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/sebfc_pkg.sv
rtl/sebfc_front.sv
rtl/sebfc_queue.sv
rtl/sebfc_back.sv
rtl/stx_etx_bcc_frame_checker_unit.sv
verif/frame_verdict_checker.sv
verif/tb.sv
